>>> src/jrss_pkg.sv
// ----------------------------------------------------------------------------
// jrss_pkg
// Shared constants, record types and the sequencer state type of the job
// record Shell sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package jrss_pkg;

   localparam int MAX_JOBS = 64;
   localparam int IDX_W    = $clog2(MAX_JOBS);
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);

   localparam int ID_W   = 16;
   localparam int TIME_W = 24;

   typedef struct packed {
      logic [ID_W-1:0]   job_id;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] duration;
      logic [TIME_W-1:0] timeout;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      logic    valid;
      rec_type rec;
      logic    last;
      logic    overflowed;
   } emit_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_T,
      S_GET_T,
      S_CMP,
      S_PUT,
      S_EMIT_RD,
      S_EMIT_WR
   } state_type;

   // True when the held record must move behind the record being inserted.
   function automatic logic goes_after(input rec_type held, input rec_type ins,
                                       input logic mode);
      logic gt;
      logic tie;
      gt  = held.arrival > ins.arrival;
      tie = mode && (held.arrival == ins.arrival) && (held.job_id > ins.job_id);
      return gt || tie;
   endfunction

endpackage

`default_nettype wire

>>> src/job_record_shell_sort_top.sv
// ----------------------------------------------------------------------------
// job_record_shell_sort_top
// Collects job records and emits them sorted by arrival time.
// ----------------------------------------------------------------------------
// Records are loaded at one beat per cycle until a beat marked last; records
// beyond 64 are dropped and flag every result of the set. The block then
// stalls its input while it Shell-sorts the store with gaps n/2 down to 1,
// every gapped insertion going through the single read and write port of
// the record memory. The sorted records then leave one at a time, each
// through a memory read and then the output register and held back while
// the receiver stalls, and the block takes the next set as soon as the
// final record sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module job_record_shell_sort_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [jrss_pkg::ID_W-1:0]    req_job_id,
   input  wire logic [jrss_pkg::TIME_W-1:0]  req_arrival,
   input  wire logic [jrss_pkg::TIME_W-1:0]  req_duration,
   input  wire logic [jrss_pkg::TIME_W-1:0]  req_timeout,
   input  wire logic                         req_last_in,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [jrss_pkg::ID_W-1:0]    rsp_out_job_id,
   output logic      [jrss_pkg::TIME_W-1:0]  rsp_out_arrival,
   output logic      [jrss_pkg::TIME_W-1:0]  rsp_out_duration,
   output logic      [jrss_pkg::TIME_W-1:0]  rsp_out_timeout,
   output logic                              rsp_last_out,
   output logic                              rsp_overflowed,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic                         csr_sort_key_mode
);

   import jrss_pkg::*;

   logic     mode_ff;
   logic     busy;
   logic     emit_ready;
   logic     load_valid;
   rec_type  load_rec;
   emit_type emit;
   logic     rsp_valid_ff;
   rec_type  rsp_rec_ff;
   logic     rsp_last_ff;
   logic     rsp_ovf_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_sort_key_mode;
      end
   end

   assign req_stall  = busy;
   assign load_valid = req_valid && !busy;
   assign emit_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      load_rec.job_id   = req_job_id;
      load_rec.arrival  = req_arrival;
      load_rec.duration = req_duration;
      load_rec.timeout  = req_timeout;
   end

   jrss_core u_core (
      .clock        (clock),
      .reset        (reset),
      .load_valid   (load_valid),
      .load_rec     (load_rec),
      .load_last    (req_last_in),
      .sort_key_mode(mode_ff),
      .emit_ready   (emit_ready),
      .busy         (busy),
      .emit         (emit)
   );

   // The core only reads a record when this register will be free for it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit.valid) begin
         rsp_rec_ff  <= emit.rec;
         rsp_last_ff <= emit.last;
         rsp_ovf_ff  <= emit.overflowed;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_job_id   = rsp_rec_ff.job_id;
   assign rsp_out_arrival  = rsp_rec_ff.arrival;
   assign rsp_out_duration = rsp_rec_ff.duration;
   assign rsp_out_timeout  = rsp_rec_ff.timeout;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

endmodule

`default_nettype wire

>>> src/jrss_ram.sv
// ----------------------------------------------------------------------------
// jrss_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module jrss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> src/jrss_core.sv
// ----------------------------------------------------------------------------
// jrss_core
// Record store and sort sequencer: loads records, runs gapped insertion
// passes over the store and reads the sorted records out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module jrss_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load_valid,
   input  wire jrss_pkg::rec_type load_rec,
   input  wire logic              load_last,
   input  wire logic              sort_key_mode,
   input  wire logic              emit_ready,
   output logic                   busy,
   output jrss_pkg::emit_type     emit
);

   import jrss_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic [IDX_W-1:0] gap_ff, gap_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   rec_type          t_ff, t_in;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   rec_type          ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   rec_type          ram_rdata;

   jrss_ram #(
      .WIDTH(REC_W),
      .DEPTH(MAX_JOBS)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
      gap_ff <= gap_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      t_ff   <= t_in;
   end

   always_comb begin
      logic [CNT_W-1:0] n_new;
      logic [IDX_W-1:0] gap_half;
      logic [IDX_W-1:0] j_next;
      logic [CNT_W-1:0] i_plus;
      logic [CNT_W-1:0] k_plus;
      logic             advance;

      state_in  = state_ff;
      count_in  = count_ff;
      drop_in   = drop_ff;
      gap_in    = gap_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      t_in      = t_ff;
      ram_we    = 1'b0;
      ram_waddr = j_ff;
      ram_wdata = t_ff;
      ram_raddr = i_ff;
      busy      = 1'b1;
      emit      = '0;
      emit.rec  = ram_rdata;
      advance   = 1'b0;
      n_new     = count_ff;
      j_next    = j_ff - gap_ff;
      i_plus    = {1'b0, i_ff} + CNT_W'(1);
      k_plus    = {1'b0, k_ff} + CNT_W'(1);
      gap_half  = gap_ff >> 1;

      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (load_valid) begin
               if (count_ff < CNT_W'(MAX_JOBS)) begin
                  ram_we    = 1'b1;
                  ram_waddr = count_ff[IDX_W-1:0];
                  ram_wdata = load_rec;
                  n_new     = count_ff + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               count_in = n_new;
               if (load_last) begin
                  gap_in = IDX_W'(n_new >> 1);
                  i_in   = IDX_W'(n_new >> 1);
                  k_in   = '0;
                  if ((n_new >> 1) == '0) begin
                     state_in = S_EMIT_RD;
                  end else begin
                     state_in = S_READ_T;
                  end
               end
            end
         end
         S_READ_T: begin
            ram_raddr = i_ff;
            state_in  = S_GET_T;
         end
         S_GET_T: begin
            t_in      = ram_rdata;
            j_in      = i_ff;
            ram_raddr = i_ff - gap_ff;
            state_in  = S_CMP;
         end
         S_CMP: begin
            if (goes_after(ram_rdata, t_ff, sort_key_mode)) begin
               ram_we    = 1'b1;
               ram_waddr = j_ff;
               ram_wdata = ram_rdata;
               j_in      = j_next;
               ram_raddr = j_next - gap_ff;
               if (j_next >= gap_ff) begin
                  state_in = S_CMP;
               end else begin
                  state_in = S_PUT;
               end
            end else begin
               ram_we    = 1'b1;
               ram_waddr = j_ff;
               ram_wdata = t_ff;
               advance   = 1'b1;
            end
         end
         S_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            ram_wdata = t_ff;
            advance   = 1'b1;
         end
         S_EMIT_RD: begin
            ram_raddr = k_ff;
            if (emit_ready) begin
               state_in = S_EMIT_WR;
            end
         end
         S_EMIT_WR: begin
            emit.valid      = 1'b1;
            emit.last       = (k_plus == count_ff);
            emit.overflowed = drop_ff;
            if (k_plus == count_ff) begin
               count_in = '0;
               drop_in  = 1'b0;
               state_in = S_IDLE;
            end else begin
               k_in     = k_plus[IDX_W-1:0];
               state_in = S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (advance) begin
         if (i_plus < count_ff) begin
            i_in     = i_plus[IDX_W-1:0];
            state_in = S_READ_T;
         end else if (gap_half == '0) begin
            k_in     = '0;
            state_in = S_EMIT_RD;
         end else begin
            gap_in   = gap_half;
            i_in     = gap_half;
            state_in = S_READ_T;
         end
      end
   end

endmodule

`default_nettype wire

>>> bench/job_record_shell_sort_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// job_record_shell_sort_top_test
// Self-checking bench for the job record Shell sorter.
// ----------------------------------------------------------------------------
// Job records are sent in sets that each end with a record marked last. A
// small in-bench model keeps its own copy of the store, Shell-sorts each set
// under the current key mode and queues the records it expects back, in
// order. Every returned beat is compared field by field with the oldest
// expected one. The run covers both key modes, ties, sets of a single record,
// full and overflowing stores, random idling on both sides and a long
// receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------

module job_record_shell_sort_top_test;

   import jrss_pkg::*;

   localparam int DRAIN_GAP = 20;
   localparam int HOLDOFF_CYCLES = 400;

   typedef struct packed {
      rec_type rec;
      logic    last;
      logic    overflowed;
   } sorted_beat_type;

   class sorted_run_board;
      rec_type         loaded[$];
      sorted_beat_type pending_beats[$];
      bit              dropped;
      bit              key_by_id = 1'b1;
      int              errors;
      int              beats_checked;
      int              overflow_sets;

      function int pending();
         return pending_beats.size();
      endfunction

      function bit ranks_behind(rec_type held, rec_type moving);
         if (held.arrival > moving.arrival) begin
            return 1'b1;
         end
         return key_by_id && held.arrival == moving.arrival && held.job_id > moving.job_id;
      endfunction

      function void take_record(rec_type r, bit last);
         rec_type         order[$];
         rec_type         t;
         sorted_beat_type b;
         int              n;
         int              gap;
         int              j;
         if (loaded.size() < MAX_JOBS) begin
            loaded = {loaded, r};
         end else begin
            dropped = 1'b1;
         end
         if (!last) begin
            return;
         end
         order = loaded;
         n = order.size();
         for (gap = n / 2; gap > 0; gap = gap / 2) begin
            for (int i = gap; i < n; i++) begin
               t = order[i];
               j = i;
               while (j >= gap && ranks_behind(order[j - gap], t)) begin
                  order[j] = order[j - gap];
                  j = j - gap;
               end
               order[j] = t;
            end
         end
         for (int k = 0; k < n; k++) begin
            b.rec = order[k];
            b.last = (k == n - 1);
            b.overflowed = dropped;
            pending_beats = {pending_beats, b};
         end
         if (dropped) begin
            overflow_sets++;
         end
         loaded.delete();
         dropped = 1'b0;
      endfunction

      task report_mismatch(string msg);
         if (errors < 30) begin
            $display("MISMATCH at %0t: %s", $time, msg);
         end
         errors++;
      endtask

      task check_beat(rec_type got, logic last, logic overflowed);
         sorted_beat_type want;
         if (pending_beats.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending, id %h", got.job_id));
            return;
         end
         want = pending_beats.pop_front();
         beats_checked++;
         if (got.job_id !== want.rec.job_id) begin
            report_mismatch($sformatf("job_id %h, expected %h", got.job_id, want.rec.job_id));
         end
         if (got.arrival !== want.rec.arrival) begin
            report_mismatch($sformatf("arrival %h, expected %h", got.arrival, want.rec.arrival));
         end
         if (got.duration !== want.rec.duration) begin
            report_mismatch($sformatf("duration %h, expected %h", got.duration,
                                      want.rec.duration));
         end
         if (got.timeout !== want.rec.timeout) begin
            report_mismatch($sformatf("timeout %h, expected %h", got.timeout, want.rec.timeout));
         end
         if (last !== want.last) begin
            report_mismatch($sformatf("last_out %b, expected %b", last, want.last));
         end
         if (overflowed !== want.overflowed) begin
            report_mismatch($sformatf("overflowed %b, expected %b", overflowed, want.overflowed));
         end
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [ID_W-1:0]     req_job_id;
   logic [TIME_W-1:0]   req_arrival;
   logic [TIME_W-1:0]   req_duration;
   logic [TIME_W-1:0]   req_timeout;
   logic                req_last_in;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [ID_W-1:0]     rsp_out_job_id;
   logic [TIME_W-1:0]   rsp_out_arrival;
   logic [TIME_W-1:0]   rsp_out_duration;
   logic [TIME_W-1:0]   rsp_out_timeout;
   logic                rsp_last_out;
   logic                rsp_overflowed;
   logic                csr_valid;
   logic                csr_ready;
   logic                csr_sort_key_mode;

   sorted_run_board runs = new();

   int send_idle_pct;
   int recv_stall_pct;
   int holdoff_left;
   int records_sent;
   int sets_sent;
   int phase_records;
   int mode_writes;

   job_record_shell_sort_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_job_id        (req_job_id),
      .req_arrival       (req_arrival),
      .req_duration      (req_duration),
      .req_timeout       (req_timeout),
      .req_last_in       (req_last_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_job_id    (rsp_out_job_id),
      .rsp_out_arrival   (rsp_out_arrival),
      .rsp_out_duration  (rsp_out_duration),
      .rsp_out_timeout   (rsp_out_timeout),
      .rsp_last_out      (rsp_last_out),
      .rsp_overflowed    (rsp_overflowed),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_sort_key_mode (csr_sort_key_mode)
   );

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            runs.check_beat('{rsp_out_job_id, rsp_out_arrival, rsp_out_duration,
                              rsp_out_timeout}, rsp_last_out, rsp_overflowed);
         end
         rsp_stall <= (holdoff_left != 0) || ($urandom_range(99) < recv_stall_pct);
      end
   end

   function automatic rec_type make_record(logic [ID_W-1:0] id, logic [TIME_W-1:0] arr,
                                           logic [TIME_W-1:0] dur, logic [TIME_W-1:0] tmo);
      rec_type r;
      r.job_id = id;
      r.arrival = arr;
      r.duration = dur;
      r.timeout = tmo;
      return r;
   endfunction

   function automatic rec_type random_record(bit tie_heavy);
      rec_type r;
      r.job_id = ($urandom_range(3) == 0) ? ID_W'($urandom_range(3)) : ID_W'($urandom);
      r.arrival = tie_heavy ? TIME_W'($urandom_range(7)) : TIME_W'($urandom);
      r.duration = TIME_W'($urandom);
      r.timeout = TIME_W'($urandom);
      return r;
   endfunction

   task automatic send_beat(rec_type r, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_job_id <= r.job_id;
      req_arrival <= r.arrival;
      req_duration <= r.duration;
      req_timeout <= r.timeout;
      req_last_in <= last;
      do begin
         @(posedge clock);
      end while (req_stall);
      runs.take_record(r, last);
      records_sent++;
      phase_records++;
      if (last) begin
         sets_sent++;
      end
   endtask

   task automatic send_set(int n, bit tie_heavy);
      for (int k = 0; k < n; k++) begin
         send_beat(random_record(tie_heavy), k == n - 1);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (runs.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic set_key_mode(bit m);
      csr_valid <= 1'b1;
      csr_sort_key_mode <= m;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      runs.key_by_id = m;
      mode_writes++;
   endtask

   task automatic run_phase(int send_pct, int recv_pct, int big_size, int budget);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      phase_records = 0;
      send_set(big_size, $urandom_range(1) == 1);
      while (phase_records < budget) begin
         send_set($urandom_range(1, 12), $urandom_range(2) == 0);
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_job_id = '0;
      req_arrival = '0;
      req_duration = '0;
      req_timeout = '0;
      req_last_in = 1'b0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_sort_key_mode = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      holdoff_left = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(make_record('1, '1, '1, '1), 1'b1);
      send_beat(make_record('0, '0, '0, '0), 1'b1);
      send_beat(make_record(16'hFFFF, 24'h000100, 24'h000001, 24'hFFFFFF), 1'b0);
      send_beat(make_record(16'h8000, 24'h000100, 24'h000002, 24'h800000), 1'b0);
      send_beat(make_record(16'h0001, 24'h000100, 24'h000003, 24'h000001), 1'b0);
      send_beat(make_record(16'h0000, 24'h000100, 24'h000004, 24'h000000), 1'b1);
      send_beat(make_record(16'h1234, 24'hFFFFFF, 24'h555555, 24'hAAAAAA), 1'b0);
      send_beat(make_record(16'h4321, 24'h000000, 24'hAAAAAA, 24'h555555), 1'b0);
      send_beat(make_record(16'h00FF, 24'h800000, 24'h0F0F0F, 24'hF0F0F0), 1'b0);
      send_beat(make_record(16'hFF00, 24'h7FFFFF, 24'hF0F0F0, 24'h0F0F0F), 1'b0);
      send_beat(make_record(16'h0F0F, 24'h000001, 24'h123456, 24'h654321), 1'b1);
      drain();
      set_key_mode(1'b0);
      send_beat(make_record(16'h0001, 24'd5, 24'd1, 24'd11), 1'b0);
      send_beat(make_record(16'h0002, 24'd5, 24'd2, 24'd12), 1'b0);
      send_beat(make_record(16'h0003, 24'd3, 24'd3, 24'd13), 1'b0);
      send_beat(make_record(16'h0004, 24'd5, 24'd4, 24'd14), 1'b0);
      send_beat(make_record(16'h0005, 24'd3, 24'd5, 24'd15), 1'b0);
      send_beat(make_record(16'h0006, 24'd5, 24'd6, 24'd16), 1'b1);
      send_beat(make_record(16'h0009, 24'd9, 24'd7, 24'd17), 1'b0);
      send_beat(make_record(16'h0008, 24'd8, 24'd8, 24'd18), 1'b1);
      drain();

      set_key_mode(1'b1);
      run_phase(0, 0, MAX_JOBS, 90);
      set_key_mode(1'b0);
      run_phase(84, 0, MAX_JOBS + 1, 90);
      set_key_mode(1'b1);
      run_phase(0, 84, MAX_JOBS + 6, 90);
      set_key_mode(1'b0);
      run_phase(12, 12, 33, 90);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      holdoff_left <= HOLDOFF_CYCLES;
      send_set(10, 1'b1);
      send_set(10, 1'b0);
      drain();
      set_key_mode(1'b1);
      run_phase(0, 0, MAX_JOBS + 2, 60);

      $display("Covered %0d records in %0d sets, %0d overflowing, with %0d key mode writes.",
               records_sent, sets_sent, runs.overflow_sets, mode_writes);
      $display("Checked %0d sorted result beats under random idling and a long hold-off.",
               runs.beats_checked);
      if (runs.errors == 0 && runs.pending() == 0) begin
         $display("job_record_shell_sort_top_test: PASS");
      end else begin
         $display("job_record_shell_sort_top_test: FAIL");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d result beats still pending.", runs.pending());
      $display("job_record_shell_sort_top_test: FAIL");
      $finish;
   end

endmodule
